[rtl/rpcw_pkg.sv]
// shared types and constants for the rgb pwm color wheel block
// no dependencies; imported by every module of the block
package rpcw_pkg;

  localparam int PHASE_W = 10;
  localparam int LEVEL_W = 8;
  localparam int LED_BITS_W = 6;

  localparam logic [PHASE_W-1:0] PHASE_TOP = 10'd512;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd0;
  localparam logic [LEVEL_W-1:0] HUE_STEP_RESET = 8'd1;

  // one led, red in the lowest bits
  typedef struct packed {
    logic [LEVEL_W-1:0] b;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] r;
  } rgb_t;

  // index 0 is the right led, index 1 the left led
  typedef rgb_t [1:0] led_pair_t;

endpackage

[rtl/rpcw_wheel_step.sv]
// one hue wheel step for a single rgb led, saturating at 0 and 255
// depends on rpcw_pkg
module rpcw_wheel_step import rpcw_pkg::*; (
  input  rgb_t               cur,
  input  logic [LEVEL_W-1:0] step,
  output rgb_t               nxt
);

  function automatic logic [LEVEL_W-1:0] sat_add(input logic [LEVEL_W-1:0] a,
                                                 input logic [LEVEL_W-1:0] s);
    logic [LEVEL_W:0] sum;
    begin
      sum = {1'b0, a} + {1'b0, s};
      sat_add = sum[LEVEL_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
    end
  endfunction

  function automatic logic [LEVEL_W-1:0] sat_sub(input logic [LEVEL_W-1:0] a,
                                                 input logic [LEVEL_W-1:0] s);
    begin
      sat_sub = (a > s) ? (a - s) : LEVEL_MIN;
    end
  endfunction

  logic r_max, g_max, b_max, r_zero, g_zero, b_zero;

  assign r_max  = (cur.r == LEVEL_MAX);
  assign g_max  = (cur.g == LEVEL_MAX);
  assign b_max  = (cur.b == LEVEL_MAX);
  assign r_zero = (cur.r == LEVEL_MIN);
  assign g_zero = (cur.g == LEVEL_MIN);
  assign b_zero = (cur.b == LEVEL_MIN);

  // first matching rule wins
  always_comb begin
    nxt = cur;
    if (r_max && !g_max && b_zero) begin
      nxt.g = sat_add(cur.g, step);
    end else if (g_max && !r_zero && b_zero) begin
      nxt.r = sat_sub(cur.r, step);
    end else if (g_max && !b_max) begin
      nxt.b = sat_add(cur.b, step);
    end else if (b_max && !g_zero) begin
      nxt.g = sat_sub(cur.g, step);
    end else if (b_max && !r_max) begin
      nxt.r = sat_add(cur.r, step);
    end else if (r_max && !b_zero) begin
      nxt.b = sat_sub(cur.b, step);
    end
  end

endmodule

[rtl/rpcw_pwm_cmp.sv]
// pwm compare of the phase against all six channel levels
// depends on rpcw_pkg
module rpcw_pwm_cmp import rpcw_pkg::*; (
  input  logic [PHASE_W-1:0]    phase,
  input  led_pair_t             leds,
  output logic [LED_BITS_W-1:0] led_bits
);

  logic              in_window;
  logic [LEVEL_W-1:0] ph;

  // only phase values below 256 drive the leds
  assign in_window = (phase[PHASE_W-1:LEVEL_W] == '0);
  assign ph        = phase[LEVEL_W-1:0];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      led_bits[3*i]   = in_window && (ph < leds[i].r);
      led_bits[3*i+1] = in_window && (ph < leds[i].g);
      led_bits[3*i+2] = in_window && (ph < leds[i].b);
    end
  end

endmodule

[rtl/rgb_pwm_color_wheel_top.sv]
// top level of the rgb pwm color wheel: input register, phase and level state,
// result register; depends on rpcw_pkg, rpcw_pwm_cmp, rpcw_wheel_step
//
//   channel  handshake          payload
//   s_*      s_tvalid/s_tready  s_tdata[0] tick
//   m_*      m_tvalid/m_tready  m_tdata[5:0] led_bits, m_tdata[6] period_start
//   cfg_*    cfg_valid/cfg_ready cfg_data hue_step
//
// one word per cycle in and out while the output is not stalled; a word passes the input
// register and then the result register; the phase/level update and the result register
// load happen together when the input register advances, so a new word can follow every cycle
// a stalled output holds the input register, which then holds s_tready low
// synchronous reset clears the phase, restores the start colors and sets hue_step to 1
// cfg_ready is always high
module rgb_pwm_color_wheel_top import rpcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [0] tick, [7:1] zero
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [5:0] led_bits, [6] period_start, [7] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data   // [7:0] hue_step
);

  logic               in_valid;
  logic               in_tick;
  logic [LEVEL_W-1:0] hue_step;
  logic [PHASE_W-1:0] pwm_phase;
  logic [PHASE_W-1:0] pwm_phase_next;
  led_pair_t          leds;
  led_pair_t          leds_stepped;
  logic [LED_BITS_W-1:0] led_bits_next;
  logic               wrap;
  logic               advance;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    pwm_phase_next = pwm_phase;
    if (in_tick) begin
      pwm_phase_next = (pwm_phase < PHASE_TOP) ? (pwm_phase + 10'd1) : '0;
    end
  end

  assign wrap = in_tick && (pwm_phase_next == '0);

  rpcw_pwm_cmp u_cmp (
    .phase    (pwm_phase_next),
    .leds     (leds),
    .led_bits (led_bits_next)
  );

  for (genvar g = 0; g < 2; g++) begin : g_led
    rpcw_wheel_step u_step (
      .cur  (leds[g]),
      .step (hue_step),
      .nxt  (leds_stepped[g])
    );
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_tick <= s_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_step <= HUE_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hue_step <= cfg_data;
    end
  end

  // state update; the word shows levels from before the step
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_phase <= '0;
      leds[0]   <= '{r: LEVEL_MIN, g: LEVEL_MAX, b: LEVEL_MIN};
      leds[1]   <= '{r: LEVEL_MAX, g: LEVEL_MIN, b: LEVEL_MIN};
    end else if (advance) begin
      pwm_phase <= pwm_phase_next;
      if (wrap) begin
        leds <= leds_stepped;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= {1'b0, wrap, led_bits_next};
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    pwm_phase <= PHASE_TOP)
    else $error("pwm phase beyond period end");

  a_start_at_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[LED_BITS_W]) |-> (pwm_phase == '0))
    else $error("period start word without phase at zero");

  a_levels_hold: assert property (@(posedge clk) disable iff (rst)
    !(advance && wrap) |=> $stable(leds))
    else $error("levels changed without a wrap");

  a_phase_inc: assert property (@(posedge clk) disable iff (rst)
    (advance && in_tick && (pwm_phase < PHASE_TOP)) |=>
      (pwm_phase == $past(pwm_phase) + 10'd1))
    else $error("phase did not advance by one");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled while input register empty");

endmodule
